// ===== rtl/core/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants for the ray to sector plane distance
// Angle constants, CORDIC table and the item records passed between stages.
// ----------------------------------------------------------------------------
package rsd_pkg;

   // CORDIC iteration count (one pipeline stage each)
   localparam int CORDIC_STEPS = 24;

   // Q3.29 angle constants
   localparam logic [31:0] ANG_PI    = 32'd1686629713;
   localparam logic [31:0] ANG_HALF  = 32'd843314857;
   localparam logic [31:0] ANG_3HALF = 32'd2529944570;
   localparam logic [31:0] ANG_TWO   = 32'd3373259426;
   localparam logic [31:0] ANG_TOL   = 32'd537;
   localparam logic signed [33:0] ANG_TOL_S = 34'sd537;

   // Q2.30 constants
   localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

   localparam logic [47:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;

   // widths
   localparam int CW = 34;   // CORDIC x, y, z
   localparam int PW = 66;   // products
   localparam int NW = 67;   // numerator, denominator, magnitudes
   localparam int QW = 48;   // quotient bits

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] dir_u;
      logic signed [31:0] dir_v;
   } geom_type;

   // angle class decided by the front end
   typedef struct packed {
      logic                 snap_cos;   // S = 0, C = 1
      logic                 snap_sin;   // S = 1, C = 0
      logic                 ang_err;
      logic                 flip;
      logic signed [CW-1:0] z;
   } cls_type;

   typedef struct packed {
      geom_type geom;
      cls_type  cls;
   } job_type;

   // arctangent table, atan(2^-i) in Q2.30
   function automatic logic signed [CW-1:0] atan_val(input int i);
      logic signed [CW-1:0] v;
      unique case (i)
         0:  v = 34'sd843314856;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043836;
         3:  v = 34'sd133525158;
         4:  v = 34'sd67021686;
         5:  v = 34'sd33543515;
         6:  v = 34'sd16775850;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194282;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048575;
         11: v = 34'sd524287;
         12: v = 34'sd262143;
         13: v = 34'sd131071;
         14: v = 34'sd65535;
         15: v = 34'sd32767;
         16: v = 34'sd16383;
         17: v = 34'sd8191;
         18: v = 34'sd4095;
         19: v = 34'sd2047;
         20: v = 34'sd1023;
         21: v = 34'sd511;
         22: v = 34'sd255;
         23: v = 34'sd127;
         24: v = 34'sd63;
         25: v = 34'sd31;
         26: v = 34'sd15;
         27: v = 34'sd7;
         28: v = 34'sd3;
         29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // |a - m| < tolerance
   function automatic logic near_ang(input logic [31:0] a, input logic [31:0] m);
      logic signed [33:0] d;
      d = $signed({2'b00, a}) - $signed({2'b00, m});
      return (d < ANG_TOL_S) && (d > -ANG_TOL_S);
   endfunction

endpackage

// ===== rtl/core/rsd_front.sv =====
// ----------------------------------------------------------------------------
// rsd_front: request intake and angle classification
// Snaps, range-checks and folds the plane angle, then hands a job to the queue.
// ----------------------------------------------------------------------------
module rsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_dir_u,
   input  logic signed [31:0]  req_dir_v,
   input  logic [31:0]         req_plane_angle,
   input  logic                q_full,
   output logic                push,
   output rsd_pkg::job_type    job
);

   logic                valid_ff;
   rsd_pkg::job_type    job_ff, job_in;
   logic                accept;
   logic signed [33:0]  fold;

   assign busy   = valid_ff && q_full;
   assign accept = start && !busy;
   assign push   = valid_ff && !q_full;
   assign job    = job_ff;

   // classify the angle
   always_comb begin
      job_in.geom.pos_x = req_pos_x;
      job_in.geom.pos_y = req_pos_y;
      job_in.geom.dir_u = req_dir_u;
      job_in.geom.dir_v = req_dir_v;
      job_in.cls.snap_cos = (req_plane_angle < rsd_pkg::ANG_TOL)
         || rsd_pkg::near_ang(req_plane_angle, rsd_pkg::ANG_PI)
         || rsd_pkg::near_ang(req_plane_angle, rsd_pkg::ANG_TWO);
      job_in.cls.snap_sin = !job_in.cls.snap_cos
         && (rsd_pkg::near_ang(req_plane_angle, rsd_pkg::ANG_HALF)
         || rsd_pkg::near_ang(req_plane_angle, rsd_pkg::ANG_3HALF));
      job_in.cls.ang_err = !job_in.cls.snap_cos && !job_in.cls.snap_sin
         && (req_plane_angle > rsd_pkg::ANG_TWO);
      job_in.cls.flip = 1'b0;
      // fold into [-pi/2, pi/2]
      priority if (req_plane_angle > rsd_pkg::ANG_3HALF) begin
         fold = $signed({2'b00, req_plane_angle}) - $signed({2'b00, rsd_pkg::ANG_TWO});
      end else if (req_plane_angle > rsd_pkg::ANG_HALF) begin
         fold = $signed({2'b00, req_plane_angle}) - $signed({2'b00, rsd_pkg::ANG_PI});
         job_in.cls.flip = 1'b1;
      end else begin
         fold = $signed({2'b00, req_plane_angle});
      end
      job_in.cls.z = fold <<< 1;
   end

   // intake register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!busy) begin
         valid_ff <= accept;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

// ===== rtl/core/rsd_queue.sv =====
// ----------------------------------------------------------------------------
// rsd_queue: two-entry job queue
// Decouples the intake from the compute pipeline.
// ----------------------------------------------------------------------------
module rsd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsd_pkg::job_type push_job,
   output logic             full,
   output logic             pop,
   output rsd_pkg::job_type pop_job
);

   rsd_pkg::job_type mem [0:1];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full    = (count_ff == 2'd2);
   // the pipeline never stalls, so drain every cycle
   assign pop     = (count_ff != 2'd0);
   assign pop_job = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== rtl/core/rsd_cordic.sv =====
// ----------------------------------------------------------------------------
// rsd_cordic: pipelined rotation-mode CORDIC
// One stage per iteration; the job record rides along.
// ----------------------------------------------------------------------------
module rsd_cordic (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  rsd_pkg::job_type             in_job,
   output logic                         out_valid,
   output rsd_pkg::job_type             out_job,
   output logic signed [rsd_pkg::CW-1:0] out_cos,
   output logic signed [rsd_pkg::CW-1:0] out_sin
);

   localparam int N = rsd_pkg::CORDIC_STEPS;

   logic                          valid_ff [0:N];
   rsd_pkg::job_type              job_ff   [0:N];
   logic signed [rsd_pkg::CW-1:0] x_ff     [0:N];
   logic signed [rsd_pkg::CW-1:0] y_ff     [0:N];

   // stage 0: start vector
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      job_ff[0] <= in_job;
      x_ff[0]   <= rsd_pkg::GAIN_Q30;
      y_ff[0]   <= '0;
   end

   // iterations
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [rsd_pkg::CW-1:0] dx, dy;
      rsd_pkg::job_type              job_in;
      logic signed [rsd_pkg::CW-1:0] x_in, y_in;

      always_comb begin
         dx     = y_ff[i] >>> i;
         dy     = x_ff[i] >>> i;
         job_in = job_ff[i];
         if (!job_ff[i].cls.z[rsd_pkg::CW-1]) begin
            x_in         = x_ff[i] - dx;
            y_in         = y_ff[i] + dy;
            job_in.cls.z = job_ff[i].cls.z - rsd_pkg::atan_val(i);
         end else begin
            x_in         = x_ff[i] + dx;
            y_in         = y_ff[i] - dy;
            job_in.cls.z = job_ff[i].cls.z + rsd_pkg::atan_val(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         job_ff[i+1] <= job_in;
         x_ff[i+1]   <= x_in;
         y_ff[i+1]   <= y_in;
      end
   end

   assign out_valid = valid_ff[N];
   assign out_job   = job_ff[N];
   assign out_cos   = x_ff[N];
   assign out_sin   = y_ff[N];

endmodule

// ===== rtl/core/rsd_back.sv =====
// ----------------------------------------------------------------------------
// rsd_back: numerator, denominator and pipelined divider
// Forms (S*x - C*y)/(C*v - S*u) one quotient bit per stage.
// ----------------------------------------------------------------------------
module rsd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  rsd_pkg::job_type              in_job,
   input  logic signed [rsd_pkg::CW-1:0] in_cos,
   input  logic signed [rsd_pkg::CW-1:0] in_sin,
   output logic                          rsp_valid,
   output logic [47:0]                   rsp_distance,
   output logic                          rsp_no_hit,
   output logic                          rsp_angle_error
);

   localparam int PW = rsd_pkg::PW;
   localparam int NW = rsd_pkg::NW;
   localparam int QW = rsd_pkg::QW;

   // ---- stage M: select S, C and multiply
   logic signed [rsd_pkg::CW-1:0] s_sel, c_sel;
   logic                  m_valid_ff, m_err_ff;
   logic signed [PW-1:0]  p_sx_ff, p_cy_ff, p_cv_ff, p_su_ff;

   always_comb begin
      priority if (in_job.cls.snap_cos) begin
         s_sel = '0;
         c_sel = rsd_pkg::ONE_Q30;
      end else if (in_job.cls.snap_sin) begin
         s_sel = rsd_pkg::ONE_Q30;
         c_sel = '0;
      end else if (in_job.cls.flip) begin
         s_sel = -in_sin;
         c_sel = -in_cos;
      end else begin
         s_sel = in_sin;
         c_sel = in_cos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else       m_valid_ff <= in_valid;
      m_err_ff <= in_job.cls.ang_err;
      p_sx_ff  <= s_sel * in_job.geom.pos_x;
      p_cy_ff  <= c_sel * in_job.geom.pos_y;
      p_cv_ff  <= c_sel * in_job.geom.dir_v;
      p_su_ff  <= s_sel * in_job.geom.dir_u;
   end

   // ---- stage D: differences
   logic                 d_valid_ff, d_err_ff;
   logic signed [NW-1:0] num_ff, den_ff;

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else       d_valid_ff <= m_valid_ff;
      d_err_ff <= m_err_ff;
      num_ff   <= NW'(p_sx_ff) - NW'(p_cy_ff);
      den_ff   <= NW'(p_cv_ff) - NW'(p_su_ff);
   end

   // ---- stage A: hit test and magnitudes
   logic          a_valid_ff, a_err_ff, a_miss_ff;
   logic [NW-1:0] an_ff, ad_ff;

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else       a_valid_ff <= d_valid_ff;
      a_err_ff  <= d_err_ff;
      a_miss_ff <= (den_ff == '0)
         || ((num_ff != '0) && (num_ff[NW-1] != den_ff[NW-1]));
      an_ff <= num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
      ad_ff <= den_ff[NW-1] ? NW'(-den_ff) : NW'(den_ff);
   end

   // ---- stage O: range check, quotient >= 2^48
   typedef struct packed {
      logic          err;
      logic          miss;
      logic          sat;
      logic [NW-1:0] an;
      logic [NW-1:0] ad;
      logic [NW-1:0] r;
      logic [QW-1:0] q;
   } div_type;

   logic    dv_valid_ff [0:QW];
   div_type dv_ff       [0:QW];

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else       dv_valid_ff[0] <= a_valid_ff;
      dv_ff[0].err  <= a_err_ff;
      dv_ff[0].miss <= a_miss_ff;
      dv_ff[0].sat  <= {18'd0, an_ff} >= {ad_ff, 18'd0};
      dv_ff[0].an   <= an_ff;
      dv_ff[0].ad   <= ad_ff;
      dv_ff[0].r    <= an_ff >> 18;
      dv_ff[0].q    <= '0;
   end

   // ---- divider: one restoring step per stage, quotient bit QW-1-k
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int B = QW - 1 - k;
      logic          nbit;
      logic [NW:0]   t;
      div_type       nx;

      if (B >= 30) begin : g_bit
         assign nbit = dv_ff[k].an[B-30];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      always_comb begin
         nx = dv_ff[k];
         t  = {dv_ff[k].r, nbit};
         if (t >= {1'b0, dv_ff[k].ad}) begin
            nx.r    = NW'(t - {1'b0, dv_ff[k].ad});
            nx.q[B] = 1'b1;
         end else begin
            nx.r    = NW'(t);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[k+1] <= 1'b0;
         else       dv_valid_ff[k+1] <= dv_valid_ff[k];
         dv_ff[k+1] <= nx;
      end
   end

   // ---- result register
   logic        out_valid_ff;
   logic [47:0] dist_ff;
   logic        nohit_ff, err_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= dv_valid_ff[QW];
      priority if (dv_ff[QW].err) begin
         dist_ff  <= '0;
         nohit_ff <= 1'b0;
      end else if (dv_ff[QW].miss) begin
         dist_ff  <= rsd_pkg::DIST_MAX;
         nohit_ff <= 1'b1;
      end else if (dv_ff[QW].sat) begin
         dist_ff  <= rsd_pkg::DIST_MAX;
         nohit_ff <= 1'b0;
      end else begin
         dist_ff  <= dv_ff[QW].q;
         nohit_ff <= 1'b0;
      end
      err_ff <= dv_ff[QW].err;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_distance    = dist_ff;
   assign rsp_no_hit      = nohit_ff;
   assign rsp_angle_error = err_ff;

endmodule

// ===== rtl/core/ray_to_sector_plane_distance_top.sv =====
// ----------------------------------------------------------------------------
// ray_to_sector_plane_distance_top: 2D ray to sector plane distance
// Path length from a point along a direction to a line through the origin.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  request  | start / busy       | req_pos_x, req_pos_y, req_dir_u, req_dir_v,
//           |                    | req_plane_angle
//  response | rsp_valid (strobe) | rsp_distance, rsp_no_hit, rsp_angle_error
//
//  One beat accepted per cycle while busy is low; each response passes through
//  the intake and queue registers, the CORDIC stages, stages M, D, A and O,
//  the 48-stage one-bit-per-stage divider and the result register.
//  Synchronous active-high reset clears all valid bits; no clearing pass.
//  The pipeline never stalls; busy rises only if the two-entry queue fills,
//  which steady one-per-cycle traffic does not cause.
// ----------------------------------------------------------------------------
module ray_to_sector_plane_distance_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_dir_u,
   input  logic signed [31:0] req_dir_v,
   input  logic [31:0]        req_plane_angle,
   output logic               rsp_valid,
   output logic [47:0]        rsp_distance,
   output logic               rsp_no_hit,
   output logic               rsp_angle_error
);

   logic                          push, q_full, pop;
   rsd_pkg::job_type              push_job, pop_job, c_job;
   logic                          c_valid;
   logic signed [rsd_pkg::CW-1:0] c_cos, c_sin;

   rsd_front u_front (
      .clock, .reset, .start, .busy,
      .req_pos_x, .req_pos_y, .req_dir_u, .req_dir_v, .req_plane_angle,
      .q_full, .push, .job(push_job)
   );

   rsd_queue u_queue (
      .clock, .reset, .push, .push_job, .full(q_full), .pop, .pop_job
   );

   rsd_cordic u_cordic (
      .clock, .reset, .in_valid(pop), .in_job(pop_job),
      .out_valid(c_valid), .out_job(c_job), .out_cos(c_cos), .out_sin(c_sin)
   );

   rsd_back u_back (
      .clock, .reset, .in_valid(c_valid), .in_job(c_job),
      .in_cos(c_cos), .in_sin(c_sin),
      .rsp_valid, .rsp_distance, .rsp_no_hit, .rsp_angle_error
   );

endmodule
